[hdl/tsbp_pkg.sv]
// Package for the text six-bit packer: payload structs, mode codes, the
// command word that links front and back, and the six-bit symbol lookup.
// No dependencies.
`timescale 1ns / 1ps

package tsbp_pkg;

  localparam int unsigned CfgDataW     = 32;
  localparam int unsigned CfgAddrW     = 3;
  localparam int unsigned CmdFifoDepth = 4;
  localparam int unsigned MaxBytes     = 4;
  localparam int unsigned ByteCntW     = 3;

  // Mode register codes; the unused code behaves as the decimal mode
  localparam logic [1:0] MODE_PASS    = 2'd0;
  localparam logic [1:0] MODE_PACK    = 2'd1;
  localparam logic [1:0] MODE_DECIMAL = 2'd2;

  // Register index of the mode register (paddr[2])
  localparam logic REG_MODE = 1'b0;

  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_run_end;
  } out_item_t;

  // One classified input: up to four bytes in emit order and their count
  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [ByteCntW-1:0]      cnt;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  // Map a byte to its six-bit code; zero means no match
  function automatic logic [5:0] six_bit_code(input logic [7:0] b);
    logic [7:0] t;
    logic [5:0] code;
    t    = 8'd0;
    code = 6'd0;
    case (b) inside
      8'h21: code = 6'd1;
      8'h22: code = 6'd2;
      8'h26: code = 6'd3;
      8'h27: code = 6'd4;
      8'h28: code = 6'd5;
      8'h29: code = 6'd6;
      8'h2C: code = 6'd7;
      8'h2E: code = 6'd8;
      8'h3A: code = 6'd9;
      8'h3B: code = 6'd10;
      8'h3F: code = 6'd11;
      [8'h41:8'h5A]: begin
        t    = b - 8'd53;
        code = t[5:0];
      end
      [8'h61:8'h7A]: begin
        t    = b - 8'd59;
        code = t[5:0];
      end
      default: code = 6'd0;
    endcase
    return code;
  endfunction

endpackage

[hdl/tsbp_front.sv]
// Front end of the packer: accepts input bytes, keeps the packing and
// decimal state, and turns each byte into a command word. Uses tsbp_pkg.
`timescale 1ns / 1ps

module tsbp_front
  import tsbp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [1:0] mode_i,
  input  logic       clear_i,
  input  in_item_t   in_item_i,
  input  logic       push_i,
  output logic       full_o,
  input  fifo_stat_t fifo_stat_i,
  output cmd_t       cmd_o,
  output logic       cmd_push_o
);

  logic [1:0]  phase_q, phase_d;
  logic [7:0]  partial_q, partial_d;
  logic [31:0] accum_q, accum_d;
  logic        accept;
  logic [5:0]  code;
  logic [7:0]  b;
  cmd_t        cmd;

  assign full_o = fifo_stat_i.full;
  assign accept = push_i && !fifo_stat_i.full;
  assign b      = in_item_i.in_byte;
  assign code   = six_bit_code(b);

  always_comb begin
    phase_d   = phase_q;
    partial_d = partial_q;
    accum_d   = accum_q;
    cmd.bytes = '0;
    cmd.cnt   = '0;
    case (mode_i)
      MODE_PASS: begin
        cmd.bytes[0] = b;
        cmd.cnt      = ByteCntW'(1);
      end
      MODE_PACK: begin
        if (code != 6'd0) begin
          case (phase_q)
            2'd0: partial_d = {code, 2'b00};
            2'd1: begin
              cmd.bytes[0] = partial_q | {6'b0, code[5:4]};
              cmd.cnt      = ByteCntW'(1);
              partial_d    = {code[3:0], 4'b0};
            end
            2'd2: begin
              cmd.bytes[0] = partial_q | {4'b0, code[5:2]};
              cmd.cnt      = ByteCntW'(1);
              partial_d    = {code[1:0], 6'b0};
            end
            default: begin
              cmd.bytes[0] = partial_q | {2'b0, code};
              cmd.cnt      = ByteCntW'(1);
              partial_d    = 8'd0;
            end
          endcase
          phase_d = phase_q + 2'd1;
        end
        // flush a nonzero partial byte at end of message
        if (in_item_i.in_last && partial_d != 8'd0) begin
          cmd.bytes[cmd.cnt[1:0]] = partial_d;
          cmd.cnt                 = cmd.cnt + ByteCntW'(1);
        end
      end
      default: begin
        if (b == CHAR_NEWLINE) begin
          cmd.bytes[0] = accum_q[31:24];
          cmd.bytes[1] = accum_q[23:16];
          cmd.bytes[2] = accum_q[15:8];
          cmd.bytes[3] = accum_q[7:0];
          cmd.cnt      = ByteCntW'(MaxBytes);
          accum_d      = 32'd0;
        end else if (b inside {[CHAR_ZERO:CHAR_NINE]}) begin
          accum_d = (accum_q << 3) + (accum_q << 1) + {28'd0, b[3:0]};
        end
      end
    endcase
    if (in_item_i.in_last) begin
      phase_d   = 2'd0;
      partial_d = 8'd0;
      accum_d   = 32'd0;
    end
  end

  assign cmd_o      = cmd;
  assign cmd_push_o = accept && (cmd.cnt != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= 2'd0;
      partial_q <= 8'd0;
      accum_q   <= 32'd0;
    end else if (clear_i) begin
      phase_q   <= 2'd0;
      partial_q <= 8'd0;
      accum_q   <= 32'd0;
    end else if (accept) begin
      phase_q   <= phase_d;
      partial_q <= partial_d;
      accum_q   <= accum_d;
    end
  end

endmodule

[hdl/tsbp_cmd_fifo.sv]
// Short command queue between the front and back of the packer.
// Uses tsbp_pkg for the command word and status struct.
`timescale 1ns / 1ps

module tsbp_cmd_fifo
  import tsbp_pkg::*;
#(
  parameter int unsigned Depth = CmdFifoDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       wr_en_i,
  input  cmd_t       wr_data_i,
  input  logic       rd_en_i,
  output cmd_t       rd_data_o,
  output fifo_stat_t stat_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            wr, rd;

  assign stat_o.full  = (cnt_q == CntW'(Depth));
  assign stat_o.empty = (cnt_q == '0);
  assign wr           = wr_en_i && !stat_o.full;
  assign rd           = rd_en_i && !stat_o.empty;
  assign rd_data_o    = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (rd) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (wr && !rd) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (rd && !wr) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_o.full |-> !wr_en_i)
    else $error("command pushed into a full queue");

  a_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en_i |-> !stat_o.empty)
    else $error("command popped from an empty queue");

  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("queue count beyond depth");

  a_head_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !stat_o.empty |-> (rd_data_o.cnt != '0))
    else $error("empty command stored in queue");

endmodule

[hdl/tsbp_back.sv]
// Back end of the packer: walks the head command one byte a cycle into
// the output register while it is empty or popped. Uses tsbp_pkg.
`timescale 1ns / 1ps

module tsbp_back
  import tsbp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cmd_t       head_i,
  input  fifo_stat_t fifo_stat_i,
  output logic       rd_en_o,
  output out_item_t  out_item_o,
  output logic       empty_o,
  input  logic       pop_i
);

  localparam int unsigned IdxW = $clog2(MaxBytes);

  logic [IdxW-1:0] idx_q, idx_d;
  logic            valid_q, valid_d;
  out_item_t       out_q, out_d;
  logic            load, take, last_byte;

  assign load      = !valid_q || pop_i;
  assign take      = load && !fifo_stat_i.empty;
  assign last_byte = ({1'b0, idx_q} + ByteCntW'(1)) == head_i.cnt;
  assign rd_en_o   = take && last_byte;

  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q;
    out_d   = out_q;
    if (load) begin
      valid_d = take;
    end
    if (take) begin
      out_d.out_byte    = head_i.bytes[idx_q];
      out_d.out_run_end = last_byte;
      idx_d             = last_byte ? '0 : idx_q + IdxW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  assign out_item_o = out_q;
  assign empty_o    = !valid_q;

endmodule

[hdl/text_six_bit_packer_top.sv]
// Top level of the text six-bit packer: mode register on the APB port,
// front end, command queue and back end. Uses tsbp_pkg and all submodules.
`timescale 1ns / 1ps

// Channel  | Direction | Handshake         | Payload
// ---------+-----------+-------------------+------------------------------
// config   | in/out    | psel/penable/     | paddr, pwdata, prdata
//          |           | pwrite, pready=1  | (mode at byte address 0)
// input    | in        | push, full        | in_item_i {in_byte, in_last}
// result   | out       | pop, empty        | out_item_o {out_byte,
//          |           |                   |   out_run_end}
//
// One input byte is accepted per cycle while the command queue has room; a byte
// that yields output queues one command of one to four result bytes.
// The back end drains one result byte per cycle while the receiver pops; a
// decimal newline gives four. Results pass the queue, then the output register.
// Reset clears the mode (pass through) and all state; a mode write clears state.
// A stalled output holds its item and backs up the queue, then full rises.

module text_six_bit_packer_top
  import tsbp_pkg::*;
#(
  parameter int unsigned CmdDepth = CmdFifoDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready,
  // input items
  input  in_item_t            in_item_i,
  input  logic                push,
  output logic                full,
  // result items
  output out_item_t           out_item_o,
  output logic                empty,
  input  logic                pop
);

  logic [1:0] mode_q;
  logic       mode_wr;
  cmd_t       cmd_in, cmd_head;
  logic       cmd_push, cmd_pop;
  fifo_stat_t fifo_stat;

  // mode register; address bit 2 selects the register
  assign pready  = 1'b1;
  assign mode_wr = psel && penable && pwrite && pready && (paddr[2] == REG_MODE);
  assign prdata  = (paddr[2] == REG_MODE) ? {{(CfgDataW - 2){1'b0}}, mode_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_PASS;
    end else if (mode_wr) begin
      mode_q <= pwdata[1:0];
    end
  end

  // classify and update state per byte
  tsbp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mode_i      (mode_q),
    .clear_i     (mode_wr),
    .in_item_i   (in_item_i),
    .push_i      (push),
    .full_o      (full),
    .fifo_stat_i (fifo_stat),
    .cmd_o       (cmd_in),
    .cmd_push_o  (cmd_push)
  );

  // hold commands between front and back
  tsbp_cmd_fifo #(
    .Depth (CmdDepth)
  ) u_cmd_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cmd_push),
    .wr_data_i (cmd_in),
    .rd_en_i   (cmd_pop),
    .rd_data_o (cmd_head),
    .stat_o    (fifo_stat)
  );

  // advance through command bytes into the output register
  tsbp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (cmd_head),
    .fifo_stat_i (fifo_stat),
    .rd_en_o     (cmd_pop),
    .out_item_o  (out_item_o),
    .empty_o     (empty),
    .pop_i       (pop)
  );

endmodule

[sim/testbench.sv]
// Self-checking testbench for text_six_bit_packer_top: drives text items in all
// modes, predicts the encoded bytes in-line and compares every result item.
// Depends on tsbp_pkg and the RTL under hdl/.
`timescale 1ns / 1ps

module testbench;
  import tsbp_pkg::*;

  // The unused mode code; the block treats it as the decimal mode
  localparam logic [1:0] MODE_SPARE = 2'd3;
  // Byte addresses: the mode register and the one unmapped register slot
  localparam logic [CfgAddrW-1:0] MODE_ADDR  = {REG_MODE, 2'b00};
  localparam logic [CfgAddrW-1:0] SPARE_ADDR = {~REG_MODE, 2'b00};
  localparam string PunctSyms = "!\"&'(),.:;?";

  // Cycles to let a result-free item settle in the block after it is taken
  localparam int SettleCycles = 10;
  // Receiver hold-off used to back up the block and raise full
  localparam int HoldCycles   = 300;
  localparam int CycleLimit   = 200000;

  logic                clk_i     = 1'b0;
  logic                rst_ni    = 1'b0;
  logic                psel      = 1'b0;
  logic                penable   = 1'b0;
  logic                pwrite    = 1'b0;
  logic [CfgAddrW-1:0] paddr     = '0;
  logic [CfgDataW-1:0] pwdata    = '0;
  logic [CfgDataW-1:0] prdata;
  logic                pready;
  in_item_t            in_item_i = '0;
  logic                push      = 1'b0;
  logic                full;
  out_item_t           out_item_o;
  logic                empty;
  logic                pop       = 1'b0;

  // Shadow of the block state, advanced once per accepted item
  logic [1:0]  mode_r    = MODE_PASS;
  logic [1:0]  phase_r   = '0;
  logic [7:0]  partial_r = '0;
  logic [31:0] accum_r   = '0;

  in_item_t    text_q[$];     // text items waiting to be offered
  out_item_t   encoded_q[$];  // encoded bytes still owed by the block

  int          err_cnt    = 0;
  int          gap_left   = 0;
  int          stall_left = 0;
  int unsigned cycle_cnt  = 0;
  logic        no_gaps    = 1'b0;
  logic        hold_out   = 1'b0;

  text_six_bit_packer_top dut (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .in_item_i,
    .push,
    .full,
    .out_item_o,
    .empty,
    .pop
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Hard stop if the block hangs or loses results
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic report(input string what);
    err_cnt++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  // Six-bit symbol code of a byte; zero when the byte is not in the table
  function automatic logic [5:0] table_code(input logic [7:0] b);
    logic [5:0] code;
    code = '0;
    for (int i = 0; i < PunctSyms.len(); i++)
      if (PunctSyms[i] == b) code = 6'(i + 1);
    if (b inside {["A":"Z"]}) code = 6'(12 + b - "A");
    if (b inside {["a":"z"]}) code = 6'(38 + b - "a");
    return code;
  endfunction

  function automatic logic [7:0] pick_sym();
    int r;
    r = $urandom_range(0, 62);
    if (r < 11) return PunctSyms[r];
    if (r < 37) return 8'("A" + r - 11);
    return 8'("a" + r - 37);
  endfunction

  // Idle length between handshakes: mostly none or short, now and then long
  function automatic int idle_len();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void clear_message();
    phase_r   = '0;
    partial_r = '0;
    accum_r   = '0;
  endfunction

  // Work out the bytes one text item produces and queue them as owed results
  task automatic encode_byte(input in_item_t it);
    logic [7:0] outs[$];
    logic [5:0] code;
    out_item_t  o;
    case (mode_r)
      MODE_PASS: outs = {outs, it.in_byte};
      MODE_PACK: begin
        code = table_code(it.in_byte);
        if (code != 0) begin
          // pack four codes MSB first into three bytes
          case (phase_r)
            2'd0: partial_r = {code, 2'b00};
            2'd1: begin
              outs = {outs, partial_r | {6'b0, code[5:4]}};
              partial_r = {code[3:0], 4'b0};
            end
            2'd2: begin
              outs = {outs, partial_r | {4'b0, code[5:2]}};
              partial_r = {code[1:0], 6'b0};
            end
            default: begin
              outs = {outs, partial_r | {2'b0, code}};
              partial_r = '0;
            end
          endcase
          phase_r = phase_r + 2'd1;
        end
        // flush a nonzero partial byte at end of message
        if (it.in_last && partial_r != 0) outs = {outs, partial_r};
      end
      default: begin
        if (it.in_byte == CHAR_NEWLINE) begin
          for (int k = 3; k >= 0; k--) outs = {outs, accum_r[8*k +: 8]};
          accum_r = '0;
        end else if (it.in_byte inside {[CHAR_ZERO:CHAR_NINE]}) begin
          accum_r = accum_r * 32'd10 + {28'd0, it.in_byte[3:0]};
        end
      end
    endcase
    if (it.in_last) clear_message();
    foreach (outs[i]) begin
      o.out_byte    = outs[i];
      o.out_run_end = (i == outs.size() - 1);
      encoded_q = {encoded_q, o};
    end
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (encoded_q.size() == 0) begin
      report($sformatf("unexpected result byte %02h", got.out_byte));
    end else begin
      want = encoded_q.pop_front();
      if (got.out_byte !== want.out_byte)
        report($sformatf("out_byte %02h, want %02h", got.out_byte, want.out_byte));
      if (got.out_run_end !== want.out_run_end)
        report($sformatf("out_run_end %b, want %b on byte %02h",
                         got.out_run_end, want.out_run_end, want.out_byte));
    end
  endtask

  // Sender: offer the head of text_q, hold it until taken, idle at random
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) begin
        encode_byte(in_item_i);
        void'(text_q.pop_front());
        gap_left = idle_len();
        if (gap_left > 0) begin
          gap_left--;
          push <= 1'b0;
        end else if (text_q.size() > 0) begin
          in_item_i <= text_q[0];
        end else begin
          push <= 1'b0;
        end
      end else if (!push) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (text_q.size() > 0) begin
          push      <= 1'b1;
          in_item_i <= text_q[0];
        end
      end
    end
  end

  // Receiver: check each popped item, stall at random, and obey hold_out
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) begin
        check_result(out_item_o);
        stall_left = idle_len();
      end
      if (hold_out || stall_left > 0) begin
        if (stall_left > 0) stall_left--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // APB write: setup cycle, then access cycle; the shadow follows the register
  task automatic reg_write(input logic [CfgAddrW-1:0] addr,
                           input logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == MODE_ADDR) begin
      mode_r = data[1:0];
      clear_message();
    end
  endtask

  // APB read of the mode register, compared with the shadow
  task automatic mode_readback();
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= MODE_ADDR;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[1:0] !== mode_r)
      report($sformatf("mode reads %0d, want %0d", prdata[1:0], mode_r));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Wait until all text is taken and every owed byte has come back
  task automatic wait_idle();
    while (text_q.size() != 0 || push || encoded_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic add_item(input logic [7:0] b, input logic last);
    in_item_t it;
    it.in_byte = b;
    it.in_last = last;
    text_q = {text_q, it};
  endtask

  task automatic add_text(input string s);
    foreach (s[i]) add_item(s[i], 1'b0);
  endtask

  // Random text for one mode; decimal mode gets mostly well-formed lines
  task automatic random_phase(input logic [1:0] mode, input int count);
    logic [CfgDataW-1:0] data;
    int                  n;
    int                  len;
    int                  r;
    wait_idle();
    data      = $urandom();
    data[1:0] = mode;
    reg_write(MODE_ADDR, data);
    mode_readback();
    n = 0;
    while (n < count) begin
      case (mode)
        MODE_PASS: begin
          add_item(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
          n++;
        end
        MODE_PACK: begin
          add_item(($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255)) : pick_sym(),
                   $urandom_range(0, 11) == 0);
          n++;
        end
        default: begin
          // long runs of digits wrap the 32-bit number
          len = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 16) : $urandom_range(0, 9);
          for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 19) == 0) add_item(8'($urandom_range(0, 255)), 1'b0);
            else add_item(8'(CHAR_ZERO + $urandom_range(0, 9)), 1'b0);
          end
          r = $urandom_range(0, 9);
          if (r == 0) add_item(8'(CHAR_ZERO + $urandom_range(0, 9)), 1'b1);
          else add_item(CHAR_NEWLINE, r == 1);
          n += len + 1;
        end
      endcase
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset value of mode is pass through; send both byte extremes
    mode_readback();
    add_item(8'h00, 1'b0);
    add_item(8'hFF, 1'b1);
    wait_idle();

    // Packing: one full group, unmatched bytes, and end-of-message flushes
    reg_write(MODE_ADDR, MODE_PACK);
    add_text("Az!?V@");
    add_item("#", 1'b1);   // partial byte left after V is flushed
    add_item("a", 1'b1);   // lone code flushed from the first slot
    add_text("Ab,");
    add_item(".", 1'b1);   // group completes, nothing to flush
    add_item("!", 1'b0);
    add_item("E", 1'b1);   // zero partial byte is dropped
    add_item("Q", 1'b0);
    wait_idle();

    // Unmapped register: must keep mode and the pending code
    reg_write(SPARE_ADDR, MODE_DECIMAL);
    mode_readback();
    add_item("B", 1'b1);
    add_item("Q", 1'b0);
    wait_idle();

    // Rewriting the mode drops the half-built group
    reg_write(MODE_ADDR, MODE_PACK);
    add_item("R", 1'b1);
    wait_idle();

    // Decimal: ignored bytes, an unterminated number, an empty line
    reg_write(MODE_ADDR, MODE_DECIMAL);
    add_text("7x\n");
    add_item("5", 1'b1);
    add_item(CHAR_NEWLINE, 1'b0);
    wait_idle();

    // Spare mode code behaves as decimal
    reg_write(MODE_ADDR, MODE_SPARE);
    mode_readback();
    add_text("12\n");

    random_phase(MODE_PACK, 45);
    random_phase(MODE_DECIMAL, 45);
    random_phase(MODE_PASS, 30);

    // Hold the receiver off while the sender streams decimal lines back to back
    no_gaps <= 1'b1;
    random_phase(MODE_DECIMAL, 40);
    hold_out <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    hold_out <= 1'b0;
    no_gaps  <= 1'b0;

    random_phase(MODE_PACK, 45);
    random_phase(MODE_SPARE, 40);
    no_gaps <= 1'b1;
    random_phase(MODE_PASS, 30);
    wait_idle();
    no_gaps <= 1'b0;
    random_phase(MODE_PACK, 25);
    random_phase(MODE_DECIMAL, 20);

    wait_idle();
    if (err_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/tsbp_pkg.sv
hdl/tsbp_front.sv
hdl/tsbp_cmd_fifo.sv
hdl/tsbp_back.sv
hdl/text_six_bit_packer_top.sv
sim/testbench.sv
